// ===== design/sha1_pkg.sv =====
// shared types and constants for the sha-1 byte stream hasher
package sha1_pkg;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hc3d2e1f0;

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int DIGEST_WORDS = 5;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_beat_t;

    // controller to datapath commands
    typedef struct packed {
        logic       wr_byte;    // write byte at byte address
        logic [5:0] wr_addr;
        logic [7:0] wr_data;
        logic       count_bits; // add 8 to bit count
        logic       round_start;// load working vars from chain
        logic       round_step; // one round
        logic [6:0] round_idx;
        logic       chain_add;  // fold working vars into chain
        logic       reinit;     // restore initial values
        logic [2:0] rd_word;    // digest word select
    } dp_cmd_t;

    typedef struct packed {
        logic [63:0] bit_count;
    } dp_status_t;

endpackage

// ===== design/sha1_byte_stream_hasher.sv =====
// sha-1 byte stream hasher top level
// absorb: one byte per cycle while not stalled; the 64th byte of a block starts a
// compression (load, 80 rounds on the single round unit, chain add)
// finish: padding writes one buffer byte a cycle, then one or two compressions,
// then five digest beats, one per cycle when output is not stalled
// input is stalled while any block or digest is in flight
// reset (rst_n low, async) restores initial chaining words and clears all counts
module sha1_byte_stream_hasher (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sha1_pkg::in_beat_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sha1_pkg::out_beat_t   out_data
);
    sha1_pkg::dp_cmd_t    cmd;
    sha1_pkg::dp_status_t status;
    logic [31:0]          word;
    logic [2:0]           idx;

    // controller sequences buffer writes, rounds and digest beats
    sha1_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_index (idx),
        .cmd       (cmd),
        .status    (status)
    );

    // datapath holds buffer, schedule, working vars and chain
    sha1_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .digest_word (word)
    );

    assign out_data.digest_word = word;
    assign out_data.word_index  = idx;
    assign out_data.last_word   = (idx == 3'(sha1_pkg::DIGEST_WORDS - 1));

`ifndef SYNTHESIS
    // no input accepted while a digest beat is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open during digest output");

    // a stalled digest beat holds its word position
    a_hold_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data.word_index)))
        else $error("digest beat changed under stall");

    // index stays within the digest
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.word_index <= 3'd4))
        else $error("digest index out of range");
`endif
endmodule

// ===== design/sha1_datapath.sv =====
// sha-1 datapath: block buffer, message schedule, round logic and chaining words
module sha1_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  sha1_pkg::dp_cmd_t   cmd,
    output sha1_pkg::dp_status_t status,
    output logic [31:0]         digest_word
);
    // w_reg holds the block as sixteen big-endian words until the schedule overwrites it
    logic [31:0] w_reg [16];
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [63:0] bits_reg;
    logic [31:0] w_cur, w_new, f_val, k_val, t_val;
    logic [3:0]  widx;

    assign widx = cmd.round_idx[3:0];

    // byte writes land in their lane, first byte of a word in the top lane
    always_ff @(posedge clk)
    begin
        if (cmd.wr_byte)
        begin
            w_reg[cmd.wr_addr[5:2]][{~cmd.wr_addr[1:0], 3'b000} +: 8] <= cmd.wr_data;
        end
        else if (cmd.round_step)
        begin
            w_reg[widx] <= w_cur;
        end
    end

    // schedule word: block word for first 16 rounds, then circular recurrence
    always_comb
    begin
        w_new = w_reg[(widx + 4'd13)] ^ w_reg[(widx + 4'd8)] ^ w_reg[(widx + 4'd2)] ^ w_reg[widx];
        w_new = {w_new[30:0], w_new[31]};
        if (cmd.round_idx < 7'd16)
        begin
            w_cur = w_reg[widx];
        end
        else
        begin
            w_cur = w_new;
        end
        if (cmd.round_idx < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1_pkg::K0;
        end
        else if (cmd.round_idx < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1_pkg::K1;
        end
        else if (cmd.round_idx < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1_pkg::K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1_pkg::K3;
        end
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + w_cur + k_val;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.round_start)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (cmd.round_step)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg[0] <= sha1_pkg::H0;
            h_reg[1] <= sha1_pkg::H1;
            h_reg[2] <= sha1_pkg::H2;
            h_reg[3] <= sha1_pkg::H3;
            h_reg[4] <= sha1_pkg::H4;
            bits_reg <= '0;
        end
        else
        begin
            if (cmd.reinit)
            begin
                h_reg[0] <= sha1_pkg::H0;
                h_reg[1] <= sha1_pkg::H1;
                h_reg[2] <= sha1_pkg::H2;
                h_reg[3] <= sha1_pkg::H3;
                h_reg[4] <= sha1_pkg::H4;
                bits_reg <= '0;
            end
            else
            begin
                if (cmd.chain_add)
                begin
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                end
                if (cmd.count_bits)
                begin
                    bits_reg <= bits_reg + 64'd8;
                end
            end
        end
    end

    always_comb
    begin
        case (cmd.rd_word)
            3'd0:    digest_word = h_reg[0];
            3'd1:    digest_word = h_reg[1];
            3'd2:    digest_word = h_reg[2];
            3'd3:    digest_word = h_reg[3];
            default: digest_word = h_reg[4];
        endcase
    end

    assign status.bit_count = bits_reg;
endmodule

// ===== design/sha1_ctrl.sv =====
// sha-1 controller: byte intake, padding sequence, round counter, digest output
module sha1_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sha1_pkg::in_beat_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            out_index,
    output sha1_pkg::dp_cmd_t     cmd,
    input  sha1_pkg::dp_status_t  status
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [5:0] fill_reg, fill_next;
    logic [6:0] round_reg, round_next;
    logic [6:0] pad_reg, pad_next;     // next pad byte address, 64 = all written
    logic       fin_reg, fin_next;     // finishing message
    logic       last_reg, last_next;   // compressing final block
    logic [2:0] word_reg, word_next;
    logic [2:0] bsel;
    logic [63:0] bc;

    assign bc = status.bit_count;
    assign bsel = pad_reg[2:0];
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign out_index = word_reg;

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        round_next = round_reg;
        pad_next   = pad_reg;
        fin_next   = fin_reg;
        last_next  = last_reg;
        word_next  = word_reg;
        cmd = '0;
        cmd.round_idx = round_reg;
        cmd.rd_word = word_reg;
        cmd.wr_addr = pad_reg[5:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.cmd == sha1_pkg::CMD_ABSORB)
                    begin
                        cmd.wr_byte = 1'b1;
                        cmd.wr_addr = fill_reg;
                        cmd.wr_data = in_data.data_byte;
                        cmd.count_bits = 1'b1;
                        fill_next = fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                        begin
                            state_next = ST_START;
                            fin_next = 1'b0;
                            last_next = 1'b0;
                        end
                    end
                    else
                    begin
                        cmd.wr_byte = 1'b1;
                        cmd.wr_addr = fill_reg;
                        cmd.wr_data = sha1_pkg::PAD_BYTE;
                        pad_next = {1'b0, fill_reg} + 7'd1;
                        fin_next = 1'b1;
                        last_next = (fill_reg < 6'd56);
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                // zero fill, length in last eight bytes when final block
                if (pad_reg == 7'd64)
                begin
                    state_next = ST_START;
                end
                else
                begin
                    cmd.wr_byte = 1'b1;
                    cmd.wr_data = 8'd0;
                    if (last_reg && pad_reg >= 7'd56)
                    begin
                        case (bsel)
                            3'd0:    cmd.wr_data = bc[63:56];
                            3'd1:    cmd.wr_data = bc[55:48];
                            3'd2:    cmd.wr_data = bc[47:40];
                            3'd3:    cmd.wr_data = bc[39:32];
                            3'd4:    cmd.wr_data = bc[31:24];
                            3'd5:    cmd.wr_data = bc[23:16];
                            3'd6:    cmd.wr_data = bc[15:8];
                            default: cmd.wr_data = bc[7:0];
                        endcase
                    end
                    pad_next = pad_reg + 7'd1;
                end
            end
            ST_START:
            begin
                cmd.round_start = 1'b1;
                round_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_step = 1'b1;
                round_next = round_reg + 7'd1;
                if (round_reg == 7'd79)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                cmd.chain_add = 1'b1;
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (last_reg)
                begin
                    word_next = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    last_next = 1'b1;
                    pad_next = '0;
                    state_next = ST_PAD;
                end
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    word_next = word_reg + 3'd1;
                    if (word_reg == 3'(sha1_pkg::DIGEST_WORDS - 1))
                    begin
                        cmd.reinit = 1'b1;
                        fill_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            round_reg <= '0;
            pad_reg   <= '0;
            fin_reg   <= 1'b0;
            last_reg  <= 1'b0;
            word_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            round_reg <= round_next;
            pad_reg   <= pad_next;
            fin_reg   <= fin_next;
            last_reg  <= last_next;
            word_reg  <= word_next;
        end
    end
endmodule
